// ===== rtl/core/wrp_pkg.sv =====
`default_nettype none
// ============================================================================
// wrp_pkg
// Shared codes and controller/datapath bus types for the weighted picker.
// ============================================================================
package wrp_pkg;

    // Result status codes
    localparam logic [1:0] ST_PICKED    = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_ABNORMAL  = 2'd2;
    localparam logic [1:0] ST_REINIT    = 2'd3;

    // Weight update modes
    localparam logic [1:0] MODE_BALANCED = 2'd0;
    localparam logic [1:0] MODE_RANDOM   = 2'd1;
    localparam logic [1:0] MODE_AVOID    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // Controller -> datapath commands
    typedef struct packed {
        logic       capture;     // latch random word, clear total and divider
        logic       reinit;      // reload all weights with the init value
        logic       pass_start;  // start a table pass at entry 0
        logic       walk_init;   // clear running sum and hit flag, preset winner to last entry
        logic       ph_sum;      // pass data accumulates into total
        logic       ph_walk;     // pass data walks cumulative sums
        logic       ph_upd;      // pass data is rewritten (balanced update)
        logic       div_step;    // one restoring-division step
        logic       zero_win;    // clear winner's weight
        logic       out_load;    // load the result register
        logic       use_pick;    // result index is the winner, else zero
        logic [1:0] status;      // result status code
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic pass_done;
        logic total_zero;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== rtl/core/wrp_dp.sv =====
`default_nettype none
// ============================================================================
// wrp_dp
// Datapath: weight memory, table pass engine, total/walk accumulators,
// bit-serial modulo unit and result register.
// ============================================================================
module wrp_dp #(
    parameter int MAX_MEMBERS = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire wrp_pkg::t_dp_cmd i_ctl,
    output wrp_pkg::t_dp_sts      o_sts,
    input  wire logic [1:0]       i_mode,
    input  wire logic [6:0]       i_member_count,
    input  wire logic [31:0]      i_random_word,
    input  wire logic             i_out_stall,
    output logic                  o_out_valid,
    output logic [5:0]            o_member_index,
    output logic [1:0]            o_status
);

    localparam int IDX_W = $clog2(MAX_MEMBERS);
    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam int TOT_W = WEIGHT_BITS + CNT_W;
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
    localparam int VW    = (CNT_W > WEIGHT_BITS) ? CNT_W : WEIGHT_BITS;
    localparam int PW    = (IDX_W > 6) ? IDX_W : 6;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;

    // active entry count, clamped to 1..MAX_MEMBERS
    logic [CW-1:0]    mc_ext;
    logic [CNT_W-1:0] act_n;
    always_comb begin
        mc_ext = CW'(i_member_count);
        if (mc_ext == '0) begin
            act_n = CNT_W'(1);
        end else if (mc_ext > CW'(MAX_MEMBERS)) begin
            act_n = CNT_W'(MAX_MEMBERS);
        end else begin
            act_n = CNT_W'(mc_ext);
        end
    end

    // reinit weight: n/2+1 (saturated) in balanced mode, else 1
    logic [VW-1:0]          half_ext;
    logic [WEIGHT_BITS-1:0] init_w;
    always_comb begin
        half_ext = VW'(act_n >> 1) + VW'(1);
        if (i_mode == wrp_pkg::MODE_BALANCED) begin
            init_w = (half_ext > VW'(WEIGHT_MAX)) ? WEIGHT_MAX : WEIGHT_BITS'(half_ext);
        end else begin
            init_w = WEIGHT_BITS'(1);
        end
    end

    // storage
    logic [WEIGHT_BITS-1:0] r_mem [MAX_MEMBERS];
    logic [WEIGHT_BITS-1:0] r_mem_q;
    logic [MAX_MEMBERS-1:0] r_vld;
    logic [WEIGHT_BITS-1:0] r_default;
    logic                   r_rd_dflt;

    // pass engine
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_issue, n_issue;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] rd_addr;

    // arithmetic
    logic [TOT_W-1:0] r_acc, r_cum, r_rem;
    logic [TOT_W-1:0] cum_n, div_rem_n;
    logic [TOT_W:0]   rem_sh, total_ext;
    logic [31:0]      r_shift;
    logic [4:0]       r_div_cnt;
    logic             r_found;
    logic [IDX_W-1:0] r_pick;
    logic             walk_hit;

    logic [WEIGHT_BITS-1:0] rd_w;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;

    logic             r_out_valid;
    logic [5:0]       r_out_idx;
    logic [1:0]       r_out_st;
    logic [PW-1:0]    pick_ext;

    assign rd_addr = r_addr[IDX_W-1:0];
    // entries never written since the last reinit read as the default weight
    assign rd_w    = r_rd_dflt ? r_default : r_mem_q;
    assign cum_n   = r_cum + TOT_W'(rd_w);
    assign walk_hit = i_ctl.ph_walk && r_rd_vld && !r_found && (cum_n > r_rem);

    // restoring division step: remainder of random word by total
    assign rem_sh    = {r_rem, r_shift[31]};
    assign total_ext = {1'b0, r_acc};
    assign div_rem_n = (rem_sh >= total_ext) ? TOT_W'(rem_sh - total_ext) : TOT_W'(rem_sh);

    // write port: the balanced rewrite of an entry comes in the cycle after its read
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_idx;
        wr_data = '0;
        if (i_ctl.ph_upd && r_rd_vld) begin
            wr_en = 1'b1;
            if (r_rd_idx == r_pick) begin
                wr_data = WEIGHT_BITS'(1);
            end else if (rd_w == WEIGHT_MAX) begin
                wr_data = rd_w;
            end else begin
                wr_data = rd_w + WEIGHT_BITS'(1);
            end
        end else if (i_ctl.zero_win) begin
            wr_en   = 1'b1;
            wr_addr = r_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_issue) begin
            r_mem_q   <= r_mem[rd_addr];
            r_rd_dflt <= !r_vld[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_default <= WEIGHT_BITS'(1);
        end else if (i_ctl.reinit) begin
            r_vld     <= '0;
            r_default <= init_w;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // pass sequencing: issue reads 0..n-1, walk stops early on a hit
    always_comb begin
        n_issue = r_issue;
        n_addr  = r_addr;
        if (i_ctl.pass_start) begin
            n_issue = 1'b1;
            n_addr  = '0;
        end else if (r_issue) begin
            n_addr = r_addr + CNT_W'(1);
            if (r_addr == act_n - CNT_W'(1) || walk_hit) begin
                n_issue = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
            r_found  <= 1'b0;
        end else begin
            r_issue  <= n_issue;
            r_rd_vld <= r_issue;
            r_addr   <= n_addr;
            if (i_ctl.walk_init) begin
                r_found <= 1'b0;
            end else if (walk_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;
        if (i_ctl.capture) begin
            r_acc     <= '0;
            r_rem     <= '0;
            r_shift   <= i_random_word;
            r_div_cnt <= '0;
        end else begin
            if (i_ctl.ph_sum && r_rd_vld) begin
                r_acc <= r_acc + TOT_W'(rd_w);
            end
            if (i_ctl.div_step) begin
                r_rem     <= div_rem_n;
                r_shift   <= {r_shift[30:0], 1'b0};
                r_div_cnt <= r_div_cnt + 5'd1;
            end
        end
        if (i_ctl.walk_init) begin
            r_cum  <= '0;
            r_pick <= IDX_W'(act_n - CNT_W'(1));
        end else if (walk_hit) begin
            r_pick <= r_rd_idx;
        end else if (i_ctl.ph_walk && r_rd_vld && !r_found) begin
            r_cum <= cum_n;
        end
    end

    // result register
    assign pick_ext = PW'(r_pick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_idx <= i_ctl.use_pick ? pick_ext[5:0] : 6'd0;
            r_out_st  <= i_ctl.status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_member_index = r_out_idx;
    assign o_status       = r_out_st;

    assign o_sts.pass_done  = !r_issue && !r_rd_vld;
    assign o_sts.total_zero = (r_acc == '0);
    assign o_sts.div_last   = (r_div_cnt == 5'd31);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

endmodule
`default_nettype wire

// ===== rtl/core/wrp_ctrl.sv =====
`default_nettype none
// ============================================================================
// wrp_ctrl
// Sequencer: sum pass, modulo, cumulative walk, weight update, result.
// ============================================================================
module wrp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_cmd,
    input  wire logic [1:0]       i_mode,
    input  wire wrp_pkg::t_dp_sts i_sts,
    output logic                  o_in_stall,
    output wrp_pkg::t_dp_cmd      o_ctl
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SUM  = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_WALK = 7'b0001000,
        S_UPD  = 7'b0010000,
        S_ZERO = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_st, n_st;
    logic       r_use_pick, n_use_pick;

    always_comb begin
        n_state    = r_state;
        n_st       = r_st;
        n_use_pick = r_use_pick;
        o_ctl      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    if (i_in_cmd) begin
                        o_ctl.reinit = 1'b1;
                        n_st         = wrp_pkg::ST_REINIT;
                        n_use_pick   = 1'b0;
                        n_state      = S_DONE;
                    end else begin
                        o_ctl.pass_start = 1'b1;
                        n_state          = S_SUM;
                    end
                end
            end
            S_SUM: begin
                o_ctl.ph_sum = 1'b1;
                if (i_sts.pass_done) begin
                    if (i_sts.total_zero) begin
                        o_ctl.reinit = 1'b1;
                        n_st = (i_mode == wrp_pkg::MODE_AVOID) ? wrp_pkg::ST_EXHAUSTED
                                                               : wrp_pkg::ST_ABNORMAL;
                        n_use_pick = 1'b0;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    o_ctl.pass_start = 1'b1;
                    o_ctl.walk_init  = 1'b1;
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                o_ctl.ph_walk = 1'b1;
                if (i_sts.pass_done) begin
                    n_st       = wrp_pkg::ST_PICKED;
                    n_use_pick = 1'b1;
                    if (i_mode == wrp_pkg::MODE_BALANCED) begin
                        o_ctl.pass_start = 1'b1;
                        n_state          = S_UPD;
                    end else if (i_mode == wrp_pkg::MODE_AVOID) begin
                        n_state = S_ZERO;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_UPD: begin
                o_ctl.ph_upd = 1'b1;
                if (i_sts.pass_done) begin
                    n_state = S_DONE;
                end
            end
            S_ZERO: begin
                o_ctl.zero_win = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                o_ctl.use_pick = r_use_pick;
                o_ctl.status   = r_st;
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_st       <= wrp_pkg::ST_PICKED;
            r_use_pick <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_st       <= n_st;
            r_use_pick <= n_use_pick;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/weighted_random_picker_core.sv =====
`default_nettype none
// ============================================================================
// weighted_random_picker_core
// Roulette-wheel weighted random selection over a weight table, with
// balanced / pure-random / avoid-repeat weight update after each draw.
// ============================================================================
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_cmd, i_random_word
//  out      | output    | o_out_valid / i_out_stall | o_member_index, o_status
//  cfg      | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
//  One transaction at a time. A balanced draw runs three passes over the
//  weight memory (sum, cumulative walk, rewrite), a 32-step serial modulo,
//  the result load and the idle state that takes the next transaction. The
//  walk ends early on a hit. Avoid-repeat and pure-random skip the rewrite
//  pass, avoid-repeat clearing the winner's weight instead; a zero total
//  ends after the sum pass, and a reinitialise goes straight to the result.
//  Reset is synchronous, active low; weights read as 1 right after reset
//  (per-entry valid bits, no clearing pass needed).
//  A stalled result holds in the output register; the next input transaction
//  is taken once that result is loaded.
//
module weighted_random_picker_core #(
    parameter int MAX_MEMBERS = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_random_word,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [5:0]       o_member_index,
    output logic [1:0]       o_status,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data
);

    // configuration registers; the user must write them only while idle, the block does not enforce it
    logic [1:0] r_mode_select;
    logic [6:0] r_member_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_select  <= wrp_pkg::MODE_RANDOM;
            r_member_count <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wrp_pkg::CFG_MODE:  r_mode_select  <= i_cfg_data[1:0];
                wrp_pkg::CFG_COUNT: r_member_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    wrp_pkg::t_dp_cmd ctl;
    wrp_pkg::t_dp_sts sts;

    // sequencer
    wrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_cmd),
        .i_mode     (r_mode_select),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_ctl      (ctl)
    );

    // weight memory, accumulators, modulo unit, result register
    wrp_dp #(
        .MAX_MEMBERS (MAX_MEMBERS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_mode         (r_mode_select),
        .i_member_count (r_member_count),
        .i_random_word  (i_random_word),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_member_index (o_member_index),
        .o_status       (o_status)
    );

endmodule
`default_nettype wire

// ===== rtl/core/wrp_checker.sv =====
`default_nettype none
// ============================================================================
// wrp_checker
// Port-level checks for the weighted picker, bound onto the top level.
// ============================================================================
module wrp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [5:0] o_member_index,
    input wire logic [1:0] o_status
);

    // stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_member_index) && $stable(o_status))
        else $error("result payload changed while stalled");

    // only a pick carries a nonzero index
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != wrp_pkg::ST_PICKED |-> o_member_index == 6'd0)
        else $error("nonzero index without a pick");

    // one transaction at a time: input closes after an accept
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after accept");

    // reset leaves the block empty and ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind weighted_random_picker_core wrp_checker u_wrp_checker (.*);
`default_nettype wire

// ===== tb/sv/weighted_random_picker_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// weighted_random_picker_checker
// Watches the config port and both channels of the picker, keeps its own
// copy of the weight table, predicts each pick and scores the results.
// ============================================================================
module weighted_random_picker_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_random_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [5:0]  i_member_index,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_checked
);

    localparam int          TABLE_DEPTH = 64;
    localparam logic [15:0] WEIGHT_SAT  = 16'hFFFF;

    typedef struct packed {
        logic [5:0] member_index;
        logic [1:0] status;
    } pick_t;

    logic [15:0] weights [0:TABLE_DEPTH-1];
    logic [1:0]  mode_sel;
    logic [6:0]  member_cnt;
    pick_t       pending_picks [$];
    int          fail_total;
    int          checked_total;

    // Count 0 acts as 1, anything past the table depth is clipped.
    function automatic int unsigned active_entries();
        if (member_cnt == 7'd0)
            return 1;
        if (member_cnt > TABLE_DEPTH)
            return TABLE_DEPTH;
        return 32'(member_cnt);
    endfunction

    // Whole table is reloaded, inactive entries too.
    task automatic refill_weights();
        logic [15:0] fill;
        fill = 16'd1;
        if (mode_sel == wrp_pkg::MODE_BALANCED)
            fill = 16'(active_entries() / 2 + 1);
        for (int k = 0; k < TABLE_DEPTH; k++)
            weights[k] = fill;
    endtask

    task automatic predict_pick(input logic cmd, input logic [31:0] word, output pick_t res);
        int unsigned n;
        int unsigned win;
        logic [63:0] total;
        logic [63:0] target;
        logic [63:0] run_sum;
        n       = active_entries();
        total   = '0;
        run_sum = '0;
        res     = '0;
        if (cmd) begin
            refill_weights();
            res.status = wrp_pkg::ST_REINIT;
            return;
        end
        for (int k = 0; k < n; k++)
            total += weights[k];
        if (total == 0) begin
            res.status = (mode_sel == wrp_pkg::MODE_AVOID) ? wrp_pkg::ST_EXHAUSTED
                                                           : wrp_pkg::ST_ABNORMAL;
            refill_weights();
            return;
        end
        target = ({32'd0, word} % total) + 64'd1;
        win    = n - 1;
        for (int k = 0; k < n; k++) begin
            run_sum += weights[k];
            if (run_sum >= target) begin
                win = k;
                break;
            end
        end
        if (mode_sel == wrp_pkg::MODE_BALANCED) begin
            weights[win] = 16'd0;
            for (int k = 0; k < n; k++)
                if (weights[k] < WEIGHT_SAT)
                    weights[k] = weights[k] + 16'd1;
        end else if (mode_sel == wrp_pkg::MODE_AVOID) begin
            weights[win] = 16'd0;
        end
        res.member_index = win[5:0];
        res.status       = wrp_pkg::ST_PICKED;
    endtask

    always @(posedge i_clk) begin
        pick_t want;
        pick_t next_pick;
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++)
                weights[k] = 16'd1;
            mode_sel   = wrp_pkg::MODE_RANDOM;
            member_cnt = 7'd64;
            pending_picks.delete();
            fail_total    = 0;
            checked_total = 0;
        end else begin
            if ($isunknown(i_out_valid)) begin
                $error("o_out_valid is unknown");
                fail_total++;
            end
            // Score the result before queuing a new one so an early result
            // cannot match its own transaction.
            if (i_out_valid && !i_out_stall) begin
                checked_total++;
                if (pending_picks.size() == 0) begin
                    $error("unexpected result: member_index %0d, status %0d",
                           i_member_index, i_status);
                    fail_total++;
                end else begin
                    want = pending_picks.pop_front();
                    if (i_member_index !== want.member_index) begin
                        $error("member_index: expected %0d, actual %0d",
                               want.member_index, i_member_index);
                        fail_total++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == wrp_pkg::CFG_MODE)
                    mode_sel = i_cfg_data[1:0];
                else
                    member_cnt = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_pick(i_cmd, i_random_word, next_pick);
                pending_picks.push_back(next_pick);
            end
        end
        o_pending    <= pending_picks.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
    end

endmodule

// ===== tb/sv/weighted_random_picker_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// weighted_random_picker_core_tb
// Drives draws and reinitialise transactions into the picker across a
// series of mode / member-count settings with varying back-pressure; the
// checker beside the DUT predicts every result and counts mismatches.
// ============================================================================
module weighted_random_picker_core_tb;

    // Unused encoding of the mode register; the block treats it as random.
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam int         RANDOM_ITEMS = 1950;
    // Worst case is a balanced draw at 64 entries plus idling on both
    // sides; this is several times the slowest clean run.
    localparam int         CYCLE_LIMIT  = 4_000_000;
    localparam int         END_SETTLE   = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_cmd;
    logic [31:0] i_random_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [5:0]  o_member_index;
    logic [1:0]  o_status;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_data;

    int pending;
    int fail_count;
    int checked;

    // Percent chance per cycle that the sender holds off / the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;

    int cycle_count = 0;
    int txn_count;
    int draw_count;
    int reinit_count;
    int setting_count;

    weighted_random_picker_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_random_word  (i_random_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_member_index (o_member_index),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    weighted_random_picker_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_random_word  (i_random_word),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_member_index (o_member_index),
        .i_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_checked      (checked)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("** weighted_random_picker_core: FAILED **");
        $finish;
    end

    // Receiver back-pressure, re-rolled every falling edge.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the
    // transaction is taken, with valid still high so back-to-back items
    // never toggle valid within one step.
    task automatic send_txn(input logic cmd, input logic [31:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_random_word <= word;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        txn_count++;
        if (cmd)
            reinit_count++;
        else
            draw_count++;
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // New register setting, written only with the block idle. The idling
    // pattern rotates with each setting so every mode sees every pattern.
    task automatic apply_setting(input logic [6:0] mode_data, input logic [6:0] count_data);
        drain();
        write_reg(wrp_pkg::CFG_MODE, mode_data);
        write_reg(wrp_pkg::CFG_COUNT, count_data);
        setting_count++;
        case (setting_count % 4)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 69;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 69;
            end
            default: begin
                send_idle_pct  = 18;
                recv_stall_pct = 18;
            end
        endcase
    endtask

    initial begin
        int          stop_at;
        int          phase_len;
        int          pause_at;
        int          roll;
        logic [1:0]  mode;
        logic [4:0]  junk;
        logic [6:0]  count;
        logic [31:0] word;

        // Every input known from time zero.
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_cmd          = 1'b0;
        i_random_word  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = wrp_pkg::CFG_MODE;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        txn_count      = 0;
        draw_count     = 0;
        reinit_count   = 0;
        setting_count  = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed ----
        // Reset setting: random mode, 64 entries of weight 1.
        send_txn(1'b0, 32'd0);            // r = 1, first entry
        send_txn(1'b0, 32'hFFFF_FFFF);    // r = total, last entry
        send_txn(1'b0, 32'd63);
        send_txn(1'b0, 32'd64);           // wraps back to entry 0
        send_txn(1'b1, $urandom);         // reinitialise, word ignored

        // Avoid repeats over two entries until the round runs dry.
        apply_setting({5'd0, wrp_pkg::MODE_AVOID}, 7'd2);
        send_txn(1'b0, 32'd0);
        send_txn(1'b0, 32'd0);            // zero-weight entry is skipped
        send_txn(1'b0, $urandom);         // all zero: round exhausted
        send_txn(1'b0, 32'hFFFF_FFFF);

        // Balanced with one entry; junk in the upper mode bits is dropped.
        apply_setting({5'b10101, wrp_pkg::MODE_BALANCED}, 7'd1);
        send_txn(1'b0, 32'd5);
        send_txn(1'b1, 32'd0);
        send_txn(1'b0, 32'hFFFF_FFFF);

        // Zero total outside avoid mode is an abnormal reset.
        apply_setting({5'd0, wrp_pkg::MODE_AVOID}, 7'd1);
        send_txn(1'b0, 32'd0);
        apply_setting({5'd0, wrp_pkg::MODE_RANDOM}, 7'd1);
        send_txn(1'b0, $urandom);
        send_txn(1'b0, 32'd0);

        // Member count zero acts as one; spare mode acts as random.
        apply_setting({5'd0, wrp_pkg::MODE_AVOID}, 7'd0);
        send_txn(1'b0, 32'hFFFF_FFFF);
        apply_setting({5'b11111, MODE_SPARE}, 7'd0);
        send_txn(1'b0, 32'd3);
        send_txn(1'b0, 32'd0);
        send_txn(1'b1, 32'hFFFF_FFFF);

        // Count above the table depth clips to 64; balanced refill is 33.
        apply_setting({5'd0, wrp_pkg::MODE_BALANCED}, 7'd127);
        send_txn(1'b1, 32'd0);
        send_txn(1'b0, 32'hFFFF_FFFF);
        send_txn(1'b0, 32'd0);

        // Balanced mode hitting a zero total.
        apply_setting({5'd0, wrp_pkg::MODE_AVOID}, 7'd1);
        send_txn(1'b0, 32'd0);
        apply_setting({5'd0, wrp_pkg::MODE_BALANCED}, 7'd1);
        send_txn(1'b0, 32'd0);

        // ---- random ----
        // Mostly small tables so avoid mode exhausts often and balanced
        // weights build up; a minority at or past the full 64 entries.
        stop_at = txn_count + RANDOM_ITEMS;
        while (txn_count < stop_at) begin
            roll = $urandom_range(99);
            mode = (roll < 10) ? MODE_SPARE : 2'($urandom_range(2));
            junk = 5'($urandom_range(31));
            roll = $urandom_range(99);
            if (roll < 5)
                count = 7'd0;
            else if (roll < 65)
                count = 7'($urandom_range(1, 12));
            else if (roll < 80)
                count = 7'($urandom_range(13, 63));
            else if (roll < 90)
                count = 7'd64;
            else
                count = 7'($urandom_range(65, 127));
            apply_setting({junk, mode}, count);

            phase_len = $urandom_range(30, 80);
            pause_at  = $urandom_range(phase_len - 1);
            for (int k = 0; k < phase_len; k++) begin
                if (k == pause_at)
                    drain();
                roll = $urandom_range(99);
                if (roll < 3)
                    word = 32'd0;
                else if (roll < 6)
                    word = 32'hFFFF_FFFF;
                else
                    word = $urandom;
                send_txn($urandom_range(99) < 6, word);
            end
        end

        // ---- wind-down ----
        drain();
        repeat (END_SETTLE) @(negedge i_clk);

        $display("Sent %0d transactions (%0d draws, %0d reinitialise) over %0d settings",
                 txn_count, draw_count, reinit_count, setting_count);
        $display("covering all four mode codes and member counts 0..127; %0d results scored.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("** weighted_random_picker_core: PASSED **");
        end else begin
            $display("** weighted_random_picker_core: FAILED **");
        end
        $finish;
    end

endmodule
